FILE: src/i2cbm_pkg.sv
// Package with the phase type, opcodes and counter sizes of the I2C byte master.
package i2cbm_pkg;

	localparam int CNT_W = 16;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_STOP  = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	typedef enum logic [3:0] {
		PH_IDLE      = 4'd0,
		PH_START1    = 4'd1,
		PH_START2    = 4'd2,
		PH_START3    = 4'd3,
		PH_STOP1     = 4'd4,
		PH_STOP2     = 4'd5,
		PH_STOP3     = 4'd6,
		PH_WR_LOW    = 4'd7,
		PH_WR_HIGH   = 4'd8,
		PH_ACK_LOW   = 4'd9,
		PH_ACK_HIGH  = 4'd10,
		PH_TAIL      = 4'd11,
		PH_RD_LOW    = 4'd12,
		PH_RD_HIGH   = 4'd13,
		PH_MACK_LOW  = 4'd14,
		PH_MACK_HIGH = 4'd15
	} phase_t;

endpackage

FILE: src/i2c_byte_master.sv
// Top level of the I2C byte master: tick input register, bus sequencer and result register.
//
//   channel | signals                                         | direction
//   in      | in_valid, in_ready, cmd_valid, opcode, tx_byte, | beat in, one bus tick
//           | sda_in                                          |
//   out     | out_valid, out_ready, scl_out, sda_out,         | beat out, one per tick
//           | busy_res, done_res, rx_byte                     |
//   cfg     | cfg_we, cfg_wdata                               | half-period write
//
// Each input beat is one bus tick and yields one output beat, by way of the input register
// and then the result register. A new beat is taken in every cycle while the output does not
// stall; the sequencer state advances as a beat moves from the input register into the result
// register. A stall on the output holds both registers and the sequencer state.
// Reset returns the sequencer to idle with both lines released and the half period at 250.
module i2c_byte_master import i2cbm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             cmd_valid,
	input  logic [1:0]       opcode,
	input  logic [7:0]       tx_byte,
	input  logic             sda_in,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             scl_out,
	output logic             sda_out,
	output logic             busy_res,
	output logic             done_res,
	output logic [7:0]       rx_byte
);

	logic             valid_s1;
	logic             cmd_valid_s1;
	logic [1:0]       opcode_s1;
	logic [7:0]       tx_byte_s1;
	logic             sda_in_s1;

	logic [CNT_W-1:0] half_period_q;
	phase_t           phase_q, phase_n;
	logic [3:0]       bit_count_q, bit_count_n;
	logic [7:0]       shift_q, shift_n;
	logic [CNT_W-1:0] tick_q, tick_n;
	logic             scl_q, scl_n;
	logic             sda_q, sda_n;
	logic [7:0]       received_q, received_n;
	logic             done_n;

	logic             out_valid_q;
	logic             step;
	logic             ent;
	phase_t           ent_ph;
	logic [CNT_W-1:0] period;
	logic [CNT_W-1:0] tick_inc;

	assign step     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || step;
	assign out_valid = out_valid_q;
	assign period   = (half_period_q == '0) ? {{(CNT_W-1){1'b0}}, 1'b1} : half_period_q;
	assign tick_inc = (tick_q < CNT_MAX) ? tick_q + 1'b1 : tick_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= CNT_W'(250);
		end else if (cfg_we) begin
			half_period_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_valid_s1 <= cmd_valid;
			opcode_s1    <= opcode;
			tx_byte_s1   <= tx_byte;
			sda_in_s1    <= sda_in;
		end
	end

	always_comb begin
		phase_n     = phase_q;
		bit_count_n = bit_count_q;
		shift_n     = shift_q;
		tick_n      = tick_q;
		scl_n       = scl_q;
		sda_n       = sda_q;
		received_n  = received_q;
		done_n      = 1'b0;
		ent         = 1'b0;
		ent_ph      = PH_IDLE;

		if (phase_q == PH_IDLE) begin
			if (cmd_valid_s1) begin
				bit_count_n = '0;
				ent         = 1'b1;
				unique case (opcode_s1)
					OP_START: ent_ph = PH_START1;
					OP_STOP:  ent_ph = PH_STOP1;
					OP_WRITE: begin
						shift_n = tx_byte_s1;
						ent_ph  = PH_WR_LOW;
					end
					default: begin
						shift_n = '0;
						ent_ph  = PH_RD_LOW;
					end
				endcase
			end
		end else begin
			tick_n = tick_inc;
			if (tick_inc >= period) begin
				if (phase_q == PH_ACK_HIGH && sda_in_s1) begin
					tick_n = period;
				end else begin
					ent = 1'b1;
					unique case (phase_q)
						PH_START1:   ent_ph = PH_START2;
						PH_START2:   ent_ph = PH_START3;
						PH_START3: begin
							ent   = 1'b0;
							scl_n = 1'b0;
						end
						PH_STOP1:    ent_ph = PH_STOP2;
						PH_STOP2:    ent_ph = PH_STOP3;
						PH_WR_LOW:   ent_ph = PH_WR_HIGH;
						PH_WR_HIGH: begin
							shift_n     = {shift_q[6:0], 1'b0};
							bit_count_n = bit_count_q + 1'b1;
							ent_ph      = (bit_count_n >= BITS_PER_BYTE) ? PH_ACK_LOW : PH_WR_LOW;
						end
						PH_ACK_LOW:  ent_ph = PH_ACK_HIGH;
						PH_ACK_HIGH: ent_ph = PH_TAIL;
						PH_RD_LOW:   ent_ph = PH_RD_HIGH;
						PH_RD_HIGH: begin
							shift_n     = {shift_q[6:0], sda_in_s1};
							bit_count_n = bit_count_q + 1'b1;
							if (bit_count_n >= BITS_PER_BYTE) begin
								received_n = shift_n;
								ent_ph     = PH_MACK_LOW;
							end else begin
								ent_ph = PH_RD_LOW;
							end
						end
						PH_MACK_LOW:  ent_ph = PH_MACK_HIGH;
						PH_MACK_HIGH: ent_ph = PH_TAIL;
						default:      ent = 1'b0;
					endcase
					if (!ent) begin
						phase_n = PH_IDLE;
						tick_n  = '0;
						done_n  = 1'b1;
					end
				end
			end
		end

		if (ent) begin
			phase_n = ent_ph;
			tick_n  = '0;
			unique case (ent_ph)
				PH_START1:    sda_n = 1'b1;
				PH_START2:    scl_n = 1'b1;
				PH_START3:    sda_n = 1'b0;
				PH_STOP1: begin
					scl_n = 1'b0;
					sda_n = 1'b0;
				end
				PH_STOP2:     scl_n = 1'b1;
				PH_STOP3:     sda_n = 1'b1;
				PH_WR_LOW: begin
					scl_n = 1'b0;
					sda_n = shift_n[7];
				end
				PH_WR_HIGH:   scl_n = 1'b1;
				PH_ACK_LOW: begin
					scl_n = 1'b0;
					sda_n = 1'b1;
				end
				PH_ACK_HIGH:  scl_n = 1'b1;
				PH_TAIL:      scl_n = 1'b0;
				PH_RD_LOW: begin
					scl_n = 1'b0;
					sda_n = 1'b1;
				end
				PH_RD_HIGH:   scl_n = 1'b1;
				PH_MACK_LOW: begin
					scl_n = 1'b0;
					sda_n = 1'b0;
				end
				PH_MACK_HIGH: scl_n = 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			bit_count_q <= '0;
			shift_q     <= '0;
			tick_q      <= '0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			received_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (step) begin
				phase_q     <= phase_n;
				bit_count_q <= bit_count_n;
				shift_q     <= shift_n;
				tick_q      <= tick_n;
				scl_q       <= scl_n;
				sda_q       <= sda_n;
				received_q  <= received_n;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			done_res <= done_n;
		end
	end

	assign scl_out  = scl_q;
	assign sda_out  = sda_q;
	assign busy_res = (phase_q != PH_IDLE);
	assign rx_byte  = received_q;

	// A completion beat always reports the sequencer as idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res)
		else $error("done beat while still busy");

	// Each step of the sequencer delivers a result beat in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		step |=> out_valid)
		else $error("sequencer step without result beat");

	// SCL is released throughout the acknowledge wait.
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_ACK_HIGH |-> scl_q)
		else $error("SCL low during acknowledge wait");

	// The phase counter never runs past the effective half period while busy, unless the half period was just rewritten.
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_IDLE |-> tick_q <= period || $past(cfg_we))
		else $error("phase counter beyond half period");

endmodule

FILE: test/i2c_byte_master_tb.sv
// Self-checking testbench for the I2C byte master: per-tick bus prediction with random flow control.
`timescale 1ns / 1ps

module i2c_byte_master_tb import i2cbm_pkg::*; ();

	localparam int QUIET_LIMIT     = 2000;
	localparam int PRESSURE_CYCLES = 300;
	localparam int DRAIN_CYCLES    = 8;

	typedef struct packed {
		logic       cmd_valid;
		logic [1:0] opcode;
		logic [7:0] tx_byte;
		logic       sda_in;
	} tick_t;

	typedef struct packed {
		logic       scl;
		logic       sda;
		logic       busy;
		logic       done;
		logic [7:0] rx;
	} bus_res_t;

	class bus_scoreboard;
		bus_res_t         expected_q[$];
		int               mismatches;
		int               checked;
		logic [CNT_W-1:0] half_period;
		phase_t           ph;
		logic [3:0]       nbits;
		logic [7:0]       shreg;
		logic [7:0]       rx_last;
		logic [CNT_W-1:0] cnt;
		logic             scl;
		logic             sda;

		function new();
			mismatches = 0;
			checked = 0;
			half_period = 16'd250;
			ph = PH_IDLE;
			nbits = '0;
			shreg = '0;
			rx_last = '0;
			cnt = '0;
			scl = 1'b1;
			sda = 1'b1;
		endfunction

		function int pending_count();
			return expected_q.size();
		endfunction

		function void enter_phase(input phase_t p);
			ph = p;
			cnt = '0;
			case (p)
				PH_START1: sda = 1'b1;
				PH_START2: scl = 1'b1;
				PH_START3: sda = 1'b0;
				PH_STOP1: begin
					scl = 1'b0;
					sda = 1'b0;
				end
				PH_STOP2: scl = 1'b1;
				PH_STOP3: sda = 1'b1;
				PH_WR_LOW: begin
					scl = 1'b0;
					sda = shreg[7];
				end
				PH_WR_HIGH: scl = 1'b1;
				PH_ACK_LOW: begin
					scl = 1'b0;
					sda = 1'b1;
				end
				PH_ACK_HIGH: scl = 1'b1;
				PH_TAIL: scl = 1'b0;
				PH_RD_LOW: begin
					scl = 1'b0;
					sda = 1'b1;
				end
				PH_RD_HIGH: scl = 1'b1;
				PH_MACK_LOW: begin
					scl = 1'b0;
					sda = 1'b0;
				end
				PH_MACK_HIGH: scl = 1'b1;
				default: ;
			endcase
		endfunction

		function void note_tick(input tick_t t);
			bus_res_t r;
			int per;
			logic done;
			done = 1'b0;
			if (ph == PH_IDLE) begin
				if (t.cmd_valid) begin
					nbits = '0;
					case (t.opcode)
						OP_START: enter_phase(PH_START1);
						OP_STOP: enter_phase(PH_STOP1);
						OP_WRITE: begin
							shreg = t.tx_byte;
							enter_phase(PH_WR_LOW);
						end
						default: begin
							shreg = '0;
							enter_phase(PH_RD_LOW);
						end
					endcase
				end
			end else begin
				per = (half_period == '0) ? 1 : int'(half_period);
				if (cnt != CNT_MAX) cnt = cnt + 1'b1;
				if (int'(cnt) >= per) begin
					if (ph == PH_ACK_HIGH && t.sda_in) begin
						cnt = CNT_W'(per);
					end else begin
						case (ph)
							PH_START1: enter_phase(PH_START2);
							PH_START2: enter_phase(PH_START3);
							PH_START3: begin
								scl = 1'b0;
								done = 1'b1;
							end
							PH_STOP1: enter_phase(PH_STOP2);
							PH_STOP2: enter_phase(PH_STOP3);
							PH_STOP3: done = 1'b1;
							PH_WR_LOW: enter_phase(PH_WR_HIGH);
							PH_WR_HIGH: begin
								shreg = {shreg[6:0], 1'b0};
								nbits = nbits + 1'b1;
								enter_phase(nbits >= BITS_PER_BYTE ? PH_ACK_LOW : PH_WR_LOW);
							end
							PH_ACK_LOW: enter_phase(PH_ACK_HIGH);
							PH_ACK_HIGH: enter_phase(PH_TAIL);
							PH_TAIL: done = 1'b1;
							PH_RD_LOW: enter_phase(PH_RD_HIGH);
							PH_RD_HIGH: begin
								shreg = {shreg[6:0], t.sda_in};
								nbits = nbits + 1'b1;
								if (nbits >= BITS_PER_BYTE) begin
									rx_last = shreg;
									enter_phase(PH_MACK_LOW);
								end else begin
									enter_phase(PH_RD_LOW);
								end
							end
							PH_MACK_LOW: enter_phase(PH_MACK_HIGH);
							PH_MACK_HIGH: enter_phase(PH_TAIL);
							default: done = 1'b1;
						endcase
						if (done) begin
							ph = PH_IDLE;
							cnt = '0;
						end
					end
				end
			end
			r.scl = scl;
			r.sda = sda;
			r.busy = (ph != PH_IDLE);
			r.done = done;
			r.rx = rx_last;
			expected_q.push_back(r);
		endfunction

		function void check_result(input bus_res_t got);
			bus_res_t want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Result beat with nothing pending: scl=%b sda=%b busy=%b done=%b rx=%h",
						got.scl, got.sda, got.busy, got.done, got.rx);
			end else begin
				want = expected_q.pop_front();
				if (got.scl !== want.scl || got.sda !== want.sda || got.busy !== want.busy ||
					got.done !== want.done || got.rx !== want.rx) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Beat %0d differs: expected scl=%b sda=%b busy=%b done=%b rx=%h, got scl=%b sda=%b busy=%b done=%b rx=%h",
							checked, want.scl, want.sda, want.busy, want.done, want.rx,
							got.scl, got.sda, got.busy, got.done, got.rx);
				end
			end
			checked++;
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             cmd_valid = 1'b0;
	logic [1:0]       opcode = OP_START;
	logic [7:0]       tx_byte = '0;
	logic             sda_in = 1'b1;
	logic             cfg_we = 1'b0;
	logic [CNT_W-1:0] cfg_wdata = '0;
	logic             out_ready = 1'b0;
	logic             in_ready;
	logic             out_valid;
	logic             scl_out;
	logic             sda_out;
	logic             busy_res;
	logic             done_res;
	logic [7:0]       rx_byte;

	bus_scoreboard sb = new();
	bus_res_t      seen;
	bit            tail_mode = 1'b0;
	bit            hold_off_req = 1'b0;
	int            ticks_sent = 0;
	int            cmd_count[4];

	i2c_byte_master DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd_valid (cmd_valid),
		.opcode    (opcode),
		.tx_byte   (tx_byte),
		.sda_in    (sda_in),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.scl_out   (scl_out),
		.sda_out   (sda_out),
		.busy_res  (busy_res),
		.done_res  (done_res),
		.rx_byte   (rx_byte)
	);

	always #5 clk = ~clk;

	task automatic drive_tick(input logic cv, input logic [1:0] op, input logic [7:0] tx,
		input logic sd);
		tick_t t;
		t = {cv, op, tx, sd};
		if (!tail_mode && $urandom_range(0, 15) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd_valid <= cv;
		opcode <= op;
		tx_byte <= tx;
		sda_in <= sd;
		do @(negedge clk); while (!in_ready);
		sb.note_tick(t);
		ticks_sent++;
		@(posedge clk);
	endtask

	task automatic run_command(input logic [1:0] op, input logic [7:0] tx, input int ack_delay,
		input logic [7:0] rd_bits, input int noise_pct);
		int ack_ticks;
		logic bit_in;
		ack_ticks = 0;
		cmd_count[op]++;
		drive_tick(1'b1, op, tx, 1'($urandom_range(0, 1)));
		while (sb.ph != PH_IDLE) begin
			if (sb.ph == PH_ACK_HIGH) begin
				bit_in = (ack_ticks >= ack_delay) ? 1'b0 : 1'b1;
				ack_ticks++;
			end else if (sb.ph == PH_RD_HIGH) begin
				bit_in = rd_bits[3'd7 - sb.nbits[2:0]];
			end else begin
				bit_in = 1'($urandom_range(0, 1));
			end
			drive_tick($urandom_range(0, 99) < noise_pct, 2'($urandom_range(0, 3)),
				8'($urandom_range(0, 255)), bit_in);
		end
	endtask

	task automatic write_half_period(input logic [CNT_W-1:0] value);
		in_valid <= 1'b0;
		while (sb.pending_count() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.half_period = value;
	endtask

	task automatic random_phase(input logic [CNT_W-1:0] hp, input int n_ticks, input bit squeeze);
		int stop_at;
		write_half_period(hp);
		if (squeeze) hold_off_req = 1'b1;
		stop_at = ticks_sent + n_ticks;
		while (ticks_sent < stop_at) begin
			repeat ($urandom_range(0, 3))
				drive_tick(1'b0, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
			run_command(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
				($urandom_range(0, 15) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 3),
				8'($urandom_range(0, 255)), 20);
		end
	endtask

	initial begin : stimulus
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_command(OP_START, 8'h00, 0, 8'h00, 10);

		write_half_period(16'd0);
		run_command(OP_START, 8'h3C, 0, 8'h00, 100);
		run_command(OP_WRITE, 8'hFF, 0, 8'h00, 0);
		run_command(OP_WRITE, 8'h00, 40, 8'h00, 0);
		run_command(OP_WRITE, 8'hA5, 2, 8'h00, 100);
		run_command(OP_READ, 8'hFF, 0, 8'hFF, 0);
		run_command(OP_READ, 8'h00, 0, 8'h00, 0);
		run_command(OP_READ, 8'h81, 0, 8'h5A, 100);
		run_command(OP_STOP, 8'h00, 0, 8'h00, 0);

		random_phase(16'd1, 300, 1'b1);
		random_phase(16'd2, 200, 1'b0);
		random_phase(16'd3, 150, 1'b0);
		random_phase(16'd6, 100, 1'b0);

		// Short phases at the end, with both sides streaming at full rate.
		tail_mode = 1'b1;
		random_phase(16'd4, 100, 1'b0);

		in_valid <= 1'b0;
		while (sb.pending_count() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Drove %0d bus ticks: %0d starts, %0d stops, %0d writes, %0d reads.",
			ticks_sent, cmd_count[OP_START], cmd_count[OP_STOP], cmd_count[OP_WRITE],
			cmd_count[OP_READ]);
		$display("Half periods 250, 0, 1, 2, 3, 6 and 4 were used; %0d result beats checked.",
			sb.checked);
		if (sb.mismatches == 0 && sb.pending_count() == 0)
			$display("PASS i2c_byte_master");
		else
			$display("FAIL i2c_byte_master");
		$finish;
	end

	initial begin : sink
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_ready <= 1'b0;
				repeat (PRESSURE_CYCLES) @(posedge clk);
			end else if (!tail_mode && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			seen = {scl_out, sda_out, busy_res, done_res, rx_byte};
			sb.check_result(seen);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(negedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("No beat moved for %0d cycles.", QUIET_LIMIT);
		$display("FAIL i2c_byte_master");
		$finish;
	end

endmodule
